[rtl/core/stq_pkg.sv]
package stq_pkg;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam logic KIND_EXPIRED = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  timer_id;
    logic [31:0] now;
    logic [31:0] delta;
    logic [31:0] period;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  fired_id;
    logic        head_valid;
    logic        head_changed;
    logic [31:0] next_delay;
    logic        overflow;
    logic        last;
  } out_t;

  // One queue slot as it sits in the memory.
  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] period;
    logic [31:0] deadline;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_PLACE,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_HEAD_RD,
    ST_STATUS
  } state_e;

endpackage

[rtl/core/stq_mem.sv]
module stq_mem import stq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IW-1:0]     waddr_i,
  input  entry_t            wdata_i,
  input  logic              re_i,
  input  logic [IW-1:0]     raddr_i,
  output entry_t            rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/stq_seq.sv]
module stq_seq import stq_pkg::*; #(
  parameter int DEPTH    = 16,
  parameter int MAX_FIRE = 32,
  parameter int IW       = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  in_t           in_i,
  input  logic          out_free_i,
  output logic          emit_o,
  output out_t          result_o,
  output logic          mem_we_o,
  output logic [IW-1:0] mem_waddr_o,
  output entry_t        mem_wdata_o,
  output logic          mem_re_o,
  output logic [IW-1:0] mem_raddr_o,
  input  entry_t        mem_rdata_i
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int FW = $clog2(MAX_FIRE + 1);

  state_e        state_q, state_d;
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [FW-1:0] fire_q, fire_d;
  logic [31:0]   now_q, now_d;
  entry_t        new_q, new_d;
  logic          hc_q, hc_d;
  logic          ov_q, ov_d;
  // Tick items are flagged by a latched request type.
  logic          tick_q, tick_d;

  logic          full;
  logic          due;
  logic [31:0]   diff;
  logic [IW-1:0] head_next;

  // Map a queue position to a memory slot of the ring.
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] head,
                                         input logic [CW-1:0] k);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(k);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  assign full      = (cnt_q == CW'(DEPTH));
  assign diff      = now_q - mem_rdata_i.deadline;
  assign due       = !diff[31];
  assign head_next = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + IW'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_i.req_type == REQ_TICK) begin
            state_d = ST_TICK_RD;
          end else if (full) begin
            state_d = ST_HEAD_RD;
          end else begin
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        state_d = (pos_q == '0) ? ST_PLACE : ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        state_d = (mem_rdata_i.deadline > new_q.deadline) ? ST_SCAN_RD : ST_PLACE;
      end
      ST_PLACE: begin
        state_d = tick_q ? ST_TICK_RD : ST_HEAD_RD;
      end
      ST_TICK_RD: begin
        state_d = ((cnt_q == '0) || (fire_q == FW'(MAX_FIRE))) ? ST_HEAD_RD : ST_TICK_CHK;
      end
      ST_TICK_CHK: begin
        if (!due) begin
          state_d = ST_STATUS;
        end else if (out_free_i) begin
          state_d = (mem_rdata_i.period != '0) ? ST_SCAN_RD : ST_TICK_RD;
        end
      end
      ST_HEAD_RD: begin
        state_d = ST_STATUS;
      end
      ST_STATUS: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    head_d      = head_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    fire_d      = fire_q;
    now_d       = now_q;
    new_d       = new_q;
    hc_d        = hc_q;
    ov_d        = ov_q;
    tick_d      = tick_q;
    in_stall_o  = 1'b1;
    emit_o      = 1'b0;
    result_o    = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = slot(head_q, pos_q);
    mem_wdata_o = new_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          now_d        = in_i.now;
          tick_d       = (in_i.req_type == REQ_TICK);
          new_d.id       = in_i.timer_id;
          new_d.period   = in_i.period;
          new_d.deadline = in_i.now + in_i.delta;
          pos_d        = cnt_q;
          fire_d       = '0;
          hc_d         = 1'b0;
          ov_d         = (in_i.req_type == REQ_INSERT) && full;
        end
      end
      ST_SCAN_RD: begin
        if (pos_q != '0) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = slot(head_q, pos_q - CW'(1));
        end
      end
      ST_SCAN_CHK: begin
        // Move a later deadline up one place; the read of the next
        // candidate is issued in ST_SCAN_RD, after this write, so no overlap.
        if (mem_rdata_i.deadline > new_q.deadline) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_i;
          pos_d       = pos_q - CW'(1);
        end
      end
      ST_PLACE: begin
        mem_we_o = 1'b1;
        cnt_d    = cnt_q + CW'(1);
        if (!tick_q) begin
          hc_d = (pos_q == '0);
        end
      end
      ST_TICK_RD: begin
        if ((cnt_q != '0) && (fire_q != FW'(MAX_FIRE))) begin
          mem_re_o = 1'b1;
        end
      end
      ST_TICK_CHK: begin
        if (due && out_free_i) begin
          emit_o            = 1'b1;
          result_o.kind     = KIND_EXPIRED;
          result_o.fired_id = mem_rdata_i.id;
          head_d            = head_next;
          cnt_d             = cnt_q - CW'(1);
          fire_d            = fire_q + FW'(1);
          pos_d             = cnt_q - CW'(1);
          new_d.id          = mem_rdata_i.id;
          new_d.period      = mem_rdata_i.period;
          new_d.deadline    = mem_rdata_i.deadline + mem_rdata_i.period;
        end
      end
      ST_HEAD_RD: begin
        mem_re_o = (cnt_q != '0);
      end
      ST_STATUS: begin
        if (out_free_i) begin
          emit_o                = 1'b1;
          result_o.kind         = KIND_STATUS;
          result_o.head_valid   = (cnt_q != '0);
          result_o.head_changed = hc_q;
          result_o.overflow     = ov_q;
          result_o.last         = 1'b1;
          if (cnt_q != '0) begin
            result_o.next_delay = (mem_rdata_i.deadline - now_q);
            if (result_o.next_delay[31]) begin
              result_o.next_delay = 32'd1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
      fire_q  <= '0;
      tick_q  <= 1'b0;
      hc_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      fire_q  <= fire_d;
      tick_q  <= tick_d;
      hc_q    <= hc_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    new_q <= new_d;
  end

endmodule

[rtl/core/sorted_deadline_timer_queue.sv]
// Sorted deadline timer queue.
// Input channel (in_valid_i / in_stall_o / in_i) takes one beat per request:
// an insert stores a timer at deadline now+delta, a tick pops due heads (at most MAX_FIRE).
// Output channel (out_valid_o / out_stall_i / out_o) gives zero or more expiry
// beats per tick, then one status beat with last set for every request.
// The queue is a ring of DEPTH slots in one memory with a registered read,
// kept sorted; a head pointer and a count track the live part.
// Insert: each timer with a later deadline is read and then moved up one slot,
// and the new timer is written into the gap; a full queue is not written.
// Tick: each due head is emitted and popped, a periodic one is re-armed at
// deadline+period through the same insert walk, and then the status beat follows.
// One request is worked at a time; in_stall_o is high until its last beat
// has been loaded into the output register and drops the cycle after.
// Reset empties the queue (count and head cleared); memory contents are left.
// While out_stall_i is high a held output beat stays and the sequencer waits to emit.
module sorted_deadline_timer_queue import stq_pkg::*; #(
  parameter int DEPTH    = 16,
  parameter int MAX_FIRE = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  localparam int IW = $clog2(DEPTH);

  logic          out_valid_q;
  out_t          out_q;
  logic          out_free;
  logic          emit;
  out_t          result;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  entry_t        mem_rdata;

  // The output register may be loaded when empty or draining this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  stq_seq #(
    .DEPTH   (DEPTH),
    .MAX_FIRE(MAX_FIRE),
    .IW      (IW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_free_i (out_free),
    .emit_o     (emit),
    .result_o   (result),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  stq_mem #(
    .DEPTH(DEPTH),
    .IW   (IW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Hold the beat while stalled; drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
